/* rtl/mmcs_pkg.sv */
// ============================================================================
// mmcs_pkg - shared definitions for the min/max contrast stretch
// Sample width, quotient width, operation codes and the structs passed
// between the range tracker, the serial divider and the top level.
// ============================================================================
package mmcs_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int PORT_BITS   = 16;
    localparam int QUOT_BITS   = 8;
    localparam int CNT_BITS    = $clog2(QUOT_BITS);
    localparam int PROD_BITS   = SAMPLE_BITS + QUOT_BITS;

    localparam logic                 OP_MEASURE = 1'b0;
    localparam logic                 OP_SCALE   = 1'b1;
    localparam logic [QUOT_BITS-1:0] SCALE_MIN  = '0;
    localparam logic [QUOT_BITS-1:0] SCALE_MAX  = '1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
    } range_t;

    typedef struct packed {
        logic                   fixed;
        logic [QUOT_BITS-1:0]   fixed_val;
        logic [SAMPLE_BITS-1:0] diff;
        logic [SAMPLE_BITS-1:0] span;
    } job_t;

endpackage

/* rtl/mmcs_range.sv */
// ============================================================================
// mmcs_range - running minimum and maximum of the measure pass
// The first measure item after reset or after a frame end loads both bounds.
// ============================================================================
module mmcs_range
    import mmcs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   upd,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   frame_end,
    output range_t                 range
);

    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic                   reseed_reg, reseed_next;

    always_comb begin
        min_next    = min_reg;
        max_next    = max_reg;
        reseed_next = reseed_reg;
        if (upd) begin
            if (reseed_reg) begin
                min_next = sample;
                max_next = sample;
            end else begin
                if (sample < min_reg) min_next = sample;
                if (sample > max_reg) max_next = sample;
            end
            reseed_next = frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg    <= '0;
            max_reg    <= '0;
            reseed_reg <= 1'b1;
        end else begin
            min_reg    <= min_next;
            max_reg    <= max_next;
            reseed_reg <= reseed_next;
        end
    end

    assign range.lo = min_reg;
    assign range.hi = max_reg;

endmodule

/* rtl/mmcs_div.sv */
// ============================================================================
// mmcs_div - radix-2 serial divider with output register
// Forms diff*255, then shifts out one quotient bit per cycle against the span.
// ============================================================================
module mmcs_div
    import mmcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  job_t                 job,
    output logic                 idle,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [QUOT_BITS-1:0] m_scaled
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_STEP,
        ST_HOLD
    } state_t;

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(QUOT_BITS - 1);

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0] rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] span_reg, span_next;
    logic [QUOT_BITS-1:0]   low_reg, low_next;
    logic [QUOT_BITS-1:0]   quot_reg, quot_next;
    logic                   m_valid_reg, m_valid_next;
    logic [QUOT_BITS-1:0]   m_scaled_reg, m_scaled_next;

    logic [PROD_BITS-1:0]   prod;
    logic [SAMPLE_BITS:0]   trial;
    logic [SAMPLE_BITS:0]   trial_sub;
    logic                   ge;

    assign prod      = {rem_reg, {QUOT_BITS{1'b0}}} - {{QUOT_BITS{1'b0}}, rem_reg};
    assign trial     = {rem_reg, low_reg[QUOT_BITS-1]};
    assign trial_sub = trial - {1'b0, span_reg};
    assign ge        = trial >= {1'b0, span_reg};

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        span_next     = span_reg;
        low_next      = low_reg;
        quot_next     = quot_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_scaled_next = m_scaled_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    rem_next  = job.diff;
                    span_next = job.span;
                    quot_next = job.fixed_val;
                    cnt_next  = '0;
                    state_next = job.fixed ? ST_HOLD : ST_PREP;
                end
            end
            ST_PREP: begin
                rem_next   = prod[PROD_BITS-1:QUOT_BITS];
                low_next   = prod[QUOT_BITS-1:0];
                state_next = ST_STEP;
            end
            ST_STEP: begin
                rem_next  = ge ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
                quot_next = {quot_reg[QUOT_BITS-2:0], ge};
                low_next  = {low_reg[QUOT_BITS-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_scaled_next = quot_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
        rem_reg      <= rem_next;
        span_reg     <= span_next;
        low_reg      <= low_next;
        quot_reg     <= quot_next;
        m_scaled_reg <= m_scaled_next;
    end

    assign idle     = state_reg == ST_IDLE;
    assign m_valid  = m_valid_reg;
    assign m_scaled = m_scaled_reg;

endmodule

/* rtl/min_max_contrast_stretch.sv */
// ============================================================================
// min_max_contrast_stretch - min/max contrast stretch to 0..255
// Measure items track the frame range; scale items are stretched through a
// serial divider and delivered through an output register.
//
//   channel   direction  ports                              item
//   s_        in         s_valid s_ready s_op s_sample       one sample
//                        s_frame_end
//   m_        out        m_valid m_ready m_scaled            one stretched value
//
// A measure item is accepted whenever it is offered, also while the divider is busy.
// A scale item strictly inside the range is loaded, then diff*255 is formed, eight
// quotient bits follow one per cycle, and the result is written to the free output register.
// A flat frame or a sample at or beyond either bound skips the division steps.
// A stalled output holds the next finished scale item in the divider.
// Reset is synchronous and clears the range to zero with reseed pending.
// ============================================================================
module min_max_contrast_stretch
    import mmcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [PORT_BITS-1:0] s_sample,
    input  logic                 s_frame_end,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [QUOT_BITS-1:0] m_scaled
);

    logic                   div_idle;
    logic                   accept;
    logic [SAMPLE_BITS-1:0] s_val;
    range_t                 range;
    job_t                   job;
    logic                   flat;
    logic                   below;
    logic                   above;

    assign s_ready = div_idle || (s_op == OP_MEASURE);
    assign accept  = s_valid && s_ready;
    assign s_val   = SAMPLE_BITS'(s_sample);

    mmcs_range u_range (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd       (accept && (s_op == OP_MEASURE)),
        .sample    (s_val),
        .frame_end (s_frame_end),
        .range     (range)
    );

    assign flat  = range.hi <= range.lo;
    assign below = s_val <= range.lo;
    assign above = s_val >= range.hi;

    assign job.fixed     = flat || below || above;
    assign job.fixed_val = (!flat && !below && above) ? SCALE_MAX : SCALE_MIN;
    assign job.diff      = s_val - range.lo;
    assign job.span      = range.hi - range.lo;

    mmcs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && (s_op == OP_SCALE)),
        .job      (job),
        .idle     (div_idle),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_scaled (m_scaled)
    );

endmodule
